// ===== rtl/core/dao_pkg.sv =====
// Shared types, constants and the gain function of the direction-aligned offset unit.
`timescale 1ns / 1ps

package dao_pkg;

   localparam int FIELD_WIDTH      = 16;
   localparam int DEF_STAGES       = 16;
   localparam int DEF_COORD_WIDTH  = 16;
   localparam int VEC_FRAC         = 24;
   localparam int VEC_GUARD        = 3;
   localparam int OFF_FRAC         = 30;
   localparam int OFF_WIDTH        = FIELD_WIDTH + 1;
   localparam int GAIN_WIDTH       = 32;
   localparam int ROT_WIDTH        = 50;
   localparam int WIDE_WIDTH       = 33;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] src_x;
      logic signed [FIELD_WIDTH-1:0] src_y;
      logic signed [FIELD_WIDTH-1:0] dest_x;
      logic signed [FIELD_WIDTH-1:0] dest_y;
      logic signed [FIELD_WIDTH-1:0] shift_x;
      logic signed [FIELD_WIDTH-1:0] shift_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] new_dest_x;
      logic signed [FIELD_WIDTH-1:0] new_dest_y;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] dest_x;
      logic signed [FIELD_WIDTH-1:0] dest_y;
      logic signed [OFF_WIDTH-1:0]   off_x;
      logic signed [OFF_WIDTH-1:0]   off_y;
      logic                          zero;
   } side_type;

   // integer square root of the accumulated CORDIC gain squared, scaled by 2^60
   function automatic longint unsigned gain_root(input int stages);
      longint unsigned p;
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      int i;
      p = 64'd1 << 30;
      for (i = 0; i < stages; i++) begin
         p = p + (p >> (2 * i));
      end
      n = p << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) begin
         b = b >> 2;
      end
      while (b != 64'd0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (r == 64'd0) begin
         r = 64'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/dao_front.sv =====
// Front end: difference vector, half-plane fold and gain-compensated offset.
`timescale 1ns / 1ps

module dao_front #(
   parameter int CORDIC_STAGES = dao_pkg::DEF_STAGES,
   parameter int COORD_WIDTH   = dao_pkg::DEF_COORD_WIDTH,
   parameter int XW            = COORD_WIDTH + dao_pkg::VEC_FRAC + dao_pkg::VEC_GUARD
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  dao_pkg::req_payload_type in_payload,
   input  logic                     mirror,
   output logic                     out_valid,
   output logic signed [XW-1:0]     out_x,
   output logic signed [XW-1:0]     out_y,
   output logic signed [dao_pkg::ROT_WIDTH-1:0] out_u,
   output logic signed [dao_pkg::ROT_WIDTH-1:0] out_v,
   output dao_pkg::side_type        out_side
);
   import dao_pkg::*;

   localparam longint unsigned ROOT = gain_root(CORDIC_STAGES);
   localparam longint unsigned GAIN_VAL = (64'd1 << 60) / ROOT;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN = GAIN_WIDTH'(GAIN_VAL);
   localparam int CW1 = COORD_WIDTH + 1;
   localparam int PW  = OFF_WIDTH + GAIN_WIDTH;

   logic signed [WIDE_WIDTH-1:0] dfx;
   logic signed [WIDE_WIDTH-1:0] dfy;

   logic                         v1_ff, v1_in;
   logic signed [COORD_WIDTH-1:0] dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic signed [OFF_WIDTH-1:0]  ox1_ff, ox1_in, oy1_ff, oy1_in;
   logic signed [FIELD_WIDTH-1:0] ex1_ff, ey1_ff;

   logic                         v2_ff;
   logic signed [CW1-1:0]        x2_ff, x2_in, y2_ff, y2_in;
   logic signed [OFF_WIDTH-1:0]  oxn2_ff, oxn2_in, oyn2_ff, oyn2_in;
   side_type                     side2_ff, side2_in;
   logic                         neg;

   logic                         v3_ff;
   logic signed [XW-1:0]         x3_ff, y3_ff;
   logic signed [ROT_WIDTH-1:0]  u3_ff, v3d_ff;
   side_type                     side3_ff;
   logic signed [PW-1:0]         pu, pv;

   assign v1_in  = in_valid;
   assign dfx    = WIDE_WIDTH'(in_payload.dest_x) - WIDE_WIDTH'(in_payload.src_x);
   assign dfy    = WIDE_WIDTH'(in_payload.dest_y) - WIDE_WIDTH'(in_payload.src_y);
   assign dx1_in = dfx[COORD_WIDTH-1:0];
   assign dy1_in = dfy[COORD_WIDTH-1:0];
   assign ox1_in = OFF_WIDTH'(in_payload.shift_x);
   assign oy1_in = mirror ? -OFF_WIDTH'(in_payload.shift_y) : OFF_WIDTH'(in_payload.shift_y);

   assign neg     = dx1_ff[COORD_WIDTH-1];
   assign x2_in   = neg ? -CW1'(dx1_ff) : CW1'(dx1_ff);
   assign y2_in   = neg ? -CW1'(dy1_ff) : CW1'(dy1_ff);
   assign oxn2_in = neg ? -ox1_ff : ox1_ff;
   assign oyn2_in = neg ? -oy1_ff : oy1_ff;

   always_comb begin
      side2_in.dest_x = ex1_ff;
      side2_in.dest_y = ey1_ff;
      side2_in.off_x  = ox1_ff;
      side2_in.off_y  = oy1_ff;
      side2_in.zero   = (dx1_ff == '0) && (dy1_ff == '0);
   end

   assign pu = oxn2_ff * GAIN;
   assign pv = oyn2_ff * GAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      ox1_ff   <= ox1_in;
      oy1_ff   <= oy1_in;
      ex1_ff   <= in_payload.dest_x;
      ey1_ff   <= in_payload.dest_y;
      x2_ff    <= x2_in;
      y2_ff    <= y2_in;
      oxn2_ff  <= oxn2_in;
      oyn2_ff  <= oyn2_in;
      side2_ff <= side2_in;
      x3_ff    <= XW'(x2_ff) <<< VEC_FRAC;
      y3_ff    <= XW'(y2_ff) <<< VEC_FRAC;
      u3_ff    <= ROT_WIDTH'(pu);
      v3d_ff   <= ROT_WIDTH'(pv);
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_u     = u3_ff;
   assign out_v     = v3d_ff;
   assign out_side  = side3_ff;

endmodule

// ===== rtl/core/dao_cordic_stage.sv =====
// One registered CORDIC micro-rotation: vectoring on (x, y), matching rotation on (u, v).
`timescale 1ns / 1ps

module dao_cordic_stage #(
   parameter int XW    = 43,
   parameter int SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [XW-1:0]  in_x,
   input  logic signed [XW-1:0]  in_y,
   input  logic signed [dao_pkg::ROT_WIDTH-1:0] in_u,
   input  logic signed [dao_pkg::ROT_WIDTH-1:0] in_v,
   input  dao_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic signed [XW-1:0]  out_x,
   output logic signed [XW-1:0]  out_y,
   output logic signed [dao_pkg::ROT_WIDTH-1:0] out_u,
   output logic signed [dao_pkg::ROT_WIDTH-1:0] out_v,
   output dao_pkg::side_type     out_side
);
   import dao_pkg::*;

   logic                        valid_ff;
   logic signed [XW-1:0]        x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ROT_WIDTH-1:0] u_ff, u_in, v_ff, v_in, us, vs;
   side_type                    side_ff;
   logic                        up;

   assign xs = in_x >>> SHIFT;
   assign ys = in_y >>> SHIFT;
   assign us = in_u >>> SHIFT;
   assign vs = in_v >>> SHIFT;
   assign up = ~in_y[XW-1];

   assign x_in = up ? in_x + ys : in_x - ys;
   assign y_in = up ? in_y - xs : in_y + xs;
   assign u_in = up ? in_u - vs : in_u + vs;
   assign v_in = up ? in_v + us : in_v - us;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/core/dao_back.sv =====
// Back end: truncate the rotated offset and subtract it from the destination.
`timescale 1ns / 1ps

module dao_back #(
   parameter int COORD_WIDTH = dao_pkg::DEF_COORD_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [dao_pkg::ROT_WIDTH-1:0] in_u,
   input  logic signed [dao_pkg::ROT_WIDTH-1:0] in_v,
   input  dao_pkg::side_type        in_side,
   output logic                     out_strobe,
   output dao_pkg::rsp_payload_type out_payload
);
   import dao_pkg::*;

   localparam logic signed [ROT_WIDTH-1:0] ROUND = ROT_WIDTH'((64'd1 << OFF_FRAC) - 64'd1);

   logic signed [ROT_WIDTH-1:0]   tu, tv, ou, ov;
   logic                          va_ff, vb_ff;
   logic signed [COORD_WIDTH-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [FIELD_WIDTH-1:0] ex_ff, ey_ff;
   logic signed [WIDE_WIDTH-1:0]  exw, eyw, rwx, rwy;
   logic signed [COORD_WIDTH-1:0] dfx, dfy;
   rsp_payload_type               pay_ff, pay_in;

   assign tu = (in_u[ROT_WIDTH-1] ? in_u + ROUND : in_u) >>> OFF_FRAC;
   assign tv = (in_v[ROT_WIDTH-1] ? in_v + ROUND : in_v) >>> OFF_FRAC;
   assign ou = ROT_WIDTH'(in_side.off_x);
   assign ov = ROT_WIDTH'(in_side.off_y);
   assign rx_in = in_side.zero ? ou[COORD_WIDTH-1:0] : tu[COORD_WIDTH-1:0];
   assign ry_in = in_side.zero ? ov[COORD_WIDTH-1:0] : tv[COORD_WIDTH-1:0];

   assign exw = WIDE_WIDTH'(ex_ff);
   assign eyw = WIDE_WIDTH'(ey_ff);
   assign dfx = exw[COORD_WIDTH-1:0] - rx_ff;
   assign dfy = eyw[COORD_WIDTH-1:0] - ry_ff;
   assign rwx = WIDE_WIDTH'(dfx);
   assign rwy = WIDE_WIDTH'(dfy);

   always_comb begin
      pay_in.new_dest_x = rwx[FIELD_WIDTH-1:0];
      pay_in.new_dest_y = rwy[FIELD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      ex_ff  <= in_side.dest_x;
      ey_ff  <= in_side.dest_y;
      pay_ff <= pay_in;
   end

   assign out_strobe  = vb_ff;
   assign out_payload = pay_ff;

endmodule

// ===== rtl/core/direction_aligned_offset_unit.sv =====
// Top level of the direction-aligned offset unit.
`timescale 1ns / 1ps
//
// Takes a source point, a destination point and a robot-frame offset and
// returns the destination moved back by the offset turned onto the
// source-to-destination direction.
// Requests: req_payload is taken at each rising edge with start high and
// busy low. busy is always low, so a request may be issued every cycle.
// Results: rsp_payload is valid for the single cycle in which rsp_strobe is
// high; results leave in request order, one per request.
// The pipeline has three front stages (difference, half-plane fold, gain
// multiply), one stage per CORDIC micro-rotation and two back stages
// (truncate, subtract). Throughput is one request per cycle, set by the
// fully unrolled rotation pipeline.
// Configuration: csr_wdata sets the mirror bit when csr_valid is high;
// csr_ready is always high. Write it only while no request is in flight.
// Reset clears the mirror bit and all valid bits of the pipeline.
// The receiver cannot stall; rsp_payload must be taken when strobed.
//
module direction_aligned_offset_unit #(
   parameter int CORDIC_STAGES = dao_pkg::DEF_STAGES,
   parameter int COORD_WIDTH   = dao_pkg::DEF_COORD_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  dao_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output dao_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_wdata
);
   import dao_pkg::*;

   localparam int XW = COORD_WIDTH + VEC_FRAC + VEC_GUARD;

   logic mirror_ff, mirror_in;
   logic accept;

   logic                        sv [0:CORDIC_STAGES];
   logic signed [XW-1:0]        sx [0:CORDIC_STAGES-1];
   logic signed [XW-1:0]        sy [0:CORDIC_STAGES-1];
   logic signed [ROT_WIDTH-1:0] su [0:CORDIC_STAGES];
   logic signed [ROT_WIDTH-1:0] sw [0:CORDIC_STAGES];
   side_type                    ss [0:CORDIC_STAGES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign mirror_in = (csr_valid && csr_ready) ? csr_wdata : mirror_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
      end else begin
         mirror_ff <= mirror_in;
      end
   end

   dao_front #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .COORD_WIDTH   (COORD_WIDTH),
      .XW            (XW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_payload (req_payload),
      .mirror     (mirror_ff),
      .out_valid  (sv[0]),
      .out_x      (sx[0]),
      .out_y      (sy[0]),
      .out_u      (su[0]),
      .out_v      (sw[0]),
      .out_side   (ss[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      if (i < CORDIC_STAGES - 1) begin : g_mid
         dao_cordic_stage #(
            .XW    (XW),
            .SHIFT (i)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (sv[i]),
            .in_x      (sx[i]),
            .in_y      (sy[i]),
            .in_u      (su[i]),
            .in_v      (sw[i]),
            .in_side   (ss[i]),
            .out_valid (sv[i+1]),
            .out_x     (sx[i+1]),
            .out_y     (sy[i+1]),
            .out_u     (su[i+1]),
            .out_v     (sw[i+1]),
            .out_side  (ss[i+1])
         );
      end else begin : g_last
         dao_cordic_stage #(
            .XW    (XW),
            .SHIFT (i)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (sv[i]),
            .in_x      (sx[i]),
            .in_y      (sy[i]),
            .in_u      (su[i]),
            .in_v      (sw[i]),
            .in_side   (ss[i]),
            .out_valid (sv[i+1]),
            .out_x     (),
            .out_y     (),
            .out_u     (su[i+1]),
            .out_v     (sw[i+1]),
            .out_side  (ss[i+1])
         );
      end
   end

   dao_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sv[CORDIC_STAGES]),
      .in_u        (su[CORDIC_STAGES]),
      .in_v        (sw[CORDIC_STAGES]),
      .in_side     (ss[CORDIC_STAGES]),
      .out_strobe  (rsp_strobe),
      .out_payload (rsp_payload)
   );

endmodule

// ===== tb/dao_offset_checker.sv =====
// Checker for the direction-aligned offset unit: predicts each corrected destination and compares.
`timescale 1ns / 1ps

module dao_offset_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  dao_pkg::req_payload_type req_payload,
   input  logic                     rsp_strobe,
   input  dao_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic                     csr_wdata,
   output int                       fail_count,
   output int                       pending
);
   import dao_pkg::*;

   localparam int STAGES     = DEF_STAGES;
   localparam int FRAC_SHIFT = OFF_FRAC;
   localparam int REPORT_MAX = 10;

   rsp_payload_type expected_dest[$];
   bit              mirror_y;
   longint          gain_comp;

   function automatic longint inverse_gain();
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned root;
      longint unsigned trial;
      int i;
      acc = 64'd1 << 30;
      for (i = 0; i < STAGES; i++) begin
         acc = acc + (acc >> (2 * i));
      end
      sq = acc << 30;
      root = 64'd0;
      for (i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= sq) begin
            root = trial;
         end
      end
      return longint'((64'd1 << 60) / root);
   endfunction

   function automatic longint wrap16(longint v);
      logic signed [FIELD_WIDTH-1:0] w;
      w = v[FIELD_WIDTH-1:0];
      return longint'(w);
   endfunction

   function automatic rsp_payload_type predict_dest(req_payload_type r, bit mirror);
      longint sx, sy, ex, ey, ox, oy;
      longint dx, dy, x, y, u, v, xs, ys, us, vs, rx, ry;
      rsp_payload_type res;
      int i;
      sx = longint'($signed(r.src_x));
      sy = longint'($signed(r.src_y));
      ex = longint'($signed(r.dest_x));
      ey = longint'($signed(r.dest_y));
      ox = longint'($signed(r.shift_x));
      oy = longint'($signed(r.shift_y));
      if (mirror) begin
         oy = -oy;
      end
      dx = wrap16(ex - sx);
      dy = wrap16(ey - sy);
      if (dx == 0 && dy == 0) begin
         rx = ox;
         ry = oy;
      end else begin
         x = dx * (longint'(1) <<< VEC_FRAC);
         y = dy * (longint'(1) <<< VEC_FRAC);
         u = ox * gain_comp;
         v = oy * gain_comp;
         if (dx < 0) begin
            x = -x;
            y = -y;
            u = -u;
            v = -v;
         end
         for (i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            us = u >>> i;
            vs = v >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               u = u - vs;
               v = v + us;
            end else begin
               x = x - ys;
               y = y + xs;
               u = u + vs;
               v = v - us;
            end
         end
         rx = (u >= 0) ? (u >>> FRAC_SHIFT) : -((-u) >>> FRAC_SHIFT);
         ry = (v >= 0) ? (v >>> FRAC_SHIFT) : -((-v) >>> FRAC_SHIFT);
      end
      rx = wrap16(rx);
      ry = wrap16(ry);
      res.new_dest_x = FIELD_WIDTH'(wrap16(ex - rx));
      res.new_dest_y = FIELD_WIDTH'(wrap16(ey - ry));
      return res;
   endfunction

   initial begin
      gain_comp = inverse_gain();
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         mirror_y = 1'b0;
         expected_dest.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_dest.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("unexpected result: x %0d y %0d",
                           $signed(rsp_payload.new_dest_x), $signed(rsp_payload.new_dest_y));
               end
            end else begin
               want = expected_dest.pop_front();
               if (want.new_dest_x !== rsp_payload.new_dest_x ||
                   want.new_dest_y !== rsp_payload.new_dest_y) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("mismatch: expected x %0d y %0d, got x %0d y %0d",
                              $signed(want.new_dest_x), $signed(want.new_dest_y),
                              $signed(rsp_payload.new_dest_x),
                              $signed(rsp_payload.new_dest_y));
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_dest.push_back(predict_dest(req_payload, mirror_y));
         end
         if (csr_valid && csr_ready) begin
            mirror_y = csr_wdata;
         end
      end
      pending = expected_dest.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the direction-aligned offset unit testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import dao_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = DEF_STAGES + 15;
   localparam int PHASE_ITEMS = 650;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_payload = '0;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic            csr_wdata = 1'b0;
   int              fail_count;
   int              pending;
   int              quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   direction_aligned_offset_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   dao_offset_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_payload_type make_req(int sx, int sy, int ex, int ey, int ox, int oy);
      req_payload_type r;
      r.src_x = sx[15:0];
      r.src_y = sy[15:0];
      r.dest_x = ex[15:0];
      r.dest_y = ey[15:0];
      r.shift_x = ox[15:0];
      r.shift_y = oy[15:0];
      return r;
   endfunction

   function automatic logic [15:0] edge_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'h0001;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_payload_type random_req();
      req_payload_type r;
      r.src_x = 16'($urandom());
      r.src_y = 16'($urandom());
      r.dest_x = 16'($urandom());
      r.dest_y = 16'($urandom());
      r.shift_x = 16'($urandom());
      r.shift_y = 16'($urandom());
      case ($urandom_range(9))
         5: begin
            r.dest_x = r.src_x;
            r.dest_y = r.src_y;
         end
         6: begin
            r.dest_x = r.src_x + 16'($urandom_range(8)) - 16'd4;
            r.dest_y = r.src_y + 16'($urandom_range(8)) - 16'd4;
         end
         7: begin
            if ($urandom_range(1)) begin
               r.dest_x = r.src_x;
            end else begin
               r.dest_y = r.src_y;
            end
         end
         8: begin
            r.src_x = edge_value();
            r.src_y = edge_value();
            r.dest_x = edge_value();
            r.dest_y = edge_value();
            r.shift_x = edge_value();
            r.shift_y = edge_value();
         end
         9: begin
            r.src_x = 16'($urandom_range(3000)) - 16'd1500;
            r.src_y = 16'($urandom_range(2000)) - 16'd1000;
            r.dest_x = 16'($urandom_range(3000)) - 16'd1500;
            r.dest_y = 16'($urandom_range(2000)) - 16'd1000;
            r.shift_x = 16'($urandom_range(400)) - 16'd200;
            r.shift_y = 16'($urandom_range(400)) - 16'd200;
         end
         default: ;
      endcase
      return r;
   endfunction

   // hold the request until taken; start stays high for the caller
   task automatic issue(req_payload_type r);
      bit taken;
      start <= 1'b1;
      req_payload <= r;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_mirror(bit m);
      bit taken;
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      issue(make_req(0, 0, 0, 0, 100, -50));
      issue(make_req(-32768, -32768, -32768, -32768, -32768, -32768));
      issue(make_req(32767, 32767, 32767, 32767, 32767, 32767));
      issue(make_req(0, 0, 1000, 0, 100, 20));
      issue(make_req(0, 0, -1000, 0, 100, 20));
      issue(make_req(0, 0, 0, 1000, 100, 20));
      issue(make_req(0, 0, 0, -1000, 100, 20));
      issue(make_req(-32768, 0, 32767, 0, 300, -300));
      issue(make_req(100, 100, -200, -300, 32767, -32768));
      issue(make_req(0, 0, 1, 1, -32768, -32768));
      issue(make_req(32767, -32768, -32768, 32767, 1, -1));
      issue(make_req(5, 5, -7, 3, 32767, 32767));
   endtask

   initial begin
      int idle_pct[3];
      bit phase_mirror[3];
      int p;
      int n;
      idle_pct = '{33, 63, 0};
      phase_mirror = '{1'b0, 1'b1, 1'b0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mirror(1'b0);
      run_directed();
      drain();
      write_mirror(1'b1);
      run_directed();
      drain();

      for (p = 0; p < 3; p++) begin
         write_mirror(phase_mirror[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            while ($urandom_range(99) < idle_pct[p]) begin
               start <= 1'b0;
               @(posedge clock);
            end
            issue(random_req());
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dao_pkg.sv
rtl/core/dao_front.sv
rtl/core/dao_cordic_stage.sv
rtl/core/dao_back.sv
rtl/core/direction_aligned_offset_unit.sv
tb/dao_offset_checker.sv
tb/tb.sv
